>>> rtl/core/pgl_pkg.sv
`timescale 1ns / 1ps
package pgl_pkg;
	localparam int GRID_ROWS_DEF      = 12;
	localparam int MAX_ROW_POINTS_DEF = 15;
	localparam int CAL_ROWS           = 12;
	localparam int CAL_PTS            = 15;
	localparam int PX_W               = 10;
	localparam int CM_W               = 7;

	typedef struct packed {
		logic [PX_W-1:0] pixel_x;
		logic [PX_W-1:0] pixel_y;
	} pix_t;

	function automatic logic [PX_W-1:0] cal_row_px(input logic [5:0] r);
		logic [PX_W-1:0] v;
		begin
			unique case (r)
				6'd0: v = 10'd472;
				6'd1: v = 10'd397;
				6'd2: v = 10'd339;
				6'd3: v = 10'd297;
				6'd4: v = 10'd262;
				6'd5: v = 10'd237;
				6'd6: v = 10'd213;
				6'd7: v = 10'd196;
				6'd8: v = 10'd180;
				6'd9: v = 10'd166;
				6'd10: v = 10'd155;
				6'd11: v = 10'd143;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	function automatic logic [3:0] cal_row_n(input logic [5:0] r);
		logic [3:0] v;
		begin
			unique case (r)
				6'd0: v = 4'd5;
				6'd1: v = 4'd6;
				6'd2: v = 4'd7;
				6'd3: v = 4'd8;
				6'd4: v = 4'd9;
				6'd5: v = 4'd10;
				6'd6: v = 4'd11;
				6'd7: v = 4'd12;
				6'd8: v = 4'd13;
				6'd9: v = 4'd13;
				6'd10: v = 4'd15;
				6'd11: v = 4'd15;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	typedef logic [PX_W-1:0] row_px_t [CAL_PTS];

	function automatic logic [PX_W-1:0] cal_col_px(input logic [5:0] r,
			input logic [5:0] k);
		row_px_t t;
		begin
			t = '{default: '0};
			unique case (r)
				6'd0: t = '{60, 184, 311, 437, 561, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
				6'd1: t = '{99, 204, 311, 419, 524, 629, 0, 0, 0, 0, 0, 0, 0, 0, 0};
				6'd2: t = '{35, 128, 219, 312, 405, 497, 589, 0, 0, 0, 0, 0, 0, 0, 0};
				6'd3: t = '{68, 153, 232, 313, 395, 476, 558, 637, 0, 0, 0, 0, 0, 0, 0};
				6'd4: t = '{22, 96, 170, 242, 313, 386, 459, 533, 605, 0, 0, 0, 0, 0, 0};
				6'd5: t = '{50, 117, 184, 250, 315, 380, 445, 512, 577, 538, 0, 0, 0, 0, 0};
				6'd6: t = '{15, 75, 135, 196, 255, 315, 374, 434, 495, 554, 614, 0, 0, 0,
					0};
				6'd7: t = '{38, 94, 150, 206, 260, 315, 369, 424, 480, 535, 590, 640, 0, 0,
					0};
				6'd8: t = '{10, 59, 112, 163, 214, 265, 315, 365, 416, 468, 518, 568, 619,
					0, 0};
				6'd9: t = '{30, 77, 125, 173, 222, 269, 315, 362, 410, 458, 505, 551, 599,
					0, 0};
				6'd10: t = '{4, 49, 93, 138, 183, 227, 272, 316, 359, 403, 448, 493, 538,
					580, 624};
				6'd11: t = '{23, 66, 106, 149, 191, 233, 275, 316, 357, 398, 440, 481, 523,
					563, 605};
				default: t = '{default: '0};
			endcase
			if (k < 6'(CAL_PTS))
				return t[k[3:0]];
			return '0;
		end
	endfunction
endpackage

>>> rtl/core/pgl_front.sv
`timescale 1ns / 1ps
module pgl_front #(
	parameter int GRID_ROWS = pgl_pkg::GRID_ROWS_DEF,
	parameter int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pgl_pkg::pix_t        in_pix,
	output logic                 q_valid,
	input  logic                 q_stall,
	output pgl_pkg::pix_t        q_pix,
	output logic [RW-1:0]        q_row
);
	import pgl_pkg::*;

	localparam int CW = RW + 1;

	logic          busy_q, done_q;
	logic [CW-1:0] lo_q, hi_q;
	pix_t          pix_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] mid;
	logic [PX_W-1:0] vlo, vhi, vmid, dlo, dhi;
	logic [PX_W-1:0] key;

	assign key = pix_q.pixel_y;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign vlo = cal_row_px(6'(lo_q));
	assign vhi = cal_row_px(6'(hi_q));
	assign vmid = cal_row_px(6'(mid));
	assign dlo = (vlo >= key) ? vlo - key : key - vlo;
	assign dhi = (vhi >= key) ? vhi - key : key - vhi;

	assign in_stall = busy_q || done_q;
	assign q_valid  = done_q;
	assign q_pix    = pix_q;
	assign q_row    = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (lo_q >= hi_q || lo_q + 1'b1 == hi_q || vmid == key) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (done_q && !q_stall) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pix_q <= in_pix;
			lo_q  <= '0;
			hi_q  <= CW'(GRID_ROWS - 1);
		end else if (busy_q) begin
			if (lo_q >= hi_q) begin
				row_q <= lo_q[RW-1:0];
			end else if (lo_q + 1'b1 == hi_q) begin
				if (vlo == key)
					row_q <= lo_q[RW-1:0];
				else if (vhi == key)
					row_q <= hi_q[RW-1:0];
				else if (dlo <= dhi)
					row_q <= lo_q[RW-1:0];
				else
					row_q <= hi_q[RW-1:0];
			end else if (vmid == key) begin
				row_q <= mid[RW-1:0];
			end else if (vmid > key) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid;
			end
		end
	end
endmodule

>>> rtl/core/pgl_queue.sv
`timescale 1ns / 1ps
module pgl_queue #(
	parameter int RW = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           w_valid,
	output logic           w_stall,
	input  pgl_pkg::pix_t  w_pix,
	input  logic [RW-1:0]  w_row,
	output logic           r_valid,
	input  logic           r_stall,
	output pgl_pkg::pix_t  r_pix,
	output logic [RW-1:0]  r_row
);
	import pgl_pkg::*;

	pix_t          pix_q [2];
	logic [RW-1:0] row_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          wr, rd;

	assign w_stall = cnt_q == 2'd2;
	assign r_valid = cnt_q != 2'd0;
	assign wr = w_valid && !w_stall;
	assign rd = r_valid && !r_stall;
	assign r_pix = pix_q[rp_q];
	assign r_row = row_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= ~wp_q;
			if (rd)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			pix_q[wp_q] <= w_pix;
			row_q[wp_q] <= w_row;
		end
	end
endmodule

>>> rtl/core/pgl_back.sv
`timescale 1ns / 1ps
module pgl_back #(
	parameter int GRID_ROWS      = pgl_pkg::GRID_ROWS_DEF,
	parameter int MAX_ROW_POINTS = pgl_pkg::MAX_ROW_POINTS_DEF,
	parameter int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_stall,
	input  pgl_pkg::pix_t              q_pix,
	input  logic [RW-1:0]              q_row,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [pgl_pkg::CM_W-1:0] floor_x_cm,
	output logic [pgl_pkg::CM_W-1:0]   floor_y_cm
);
	import pgl_pkg::*;

	localparam int CW = $clog2(MAX_ROW_POINTS + 1) + 1;

	logic            busy_q, done_q;
	logic [CW-1:0]   lo_q, hi_q, mid, col;
	logic [PX_W-1:0] key;
	logic [RW-1:0]   row_q;
	logic [5:0]      row6;
	logic [PX_W-1:0] vlo, vhi, vmid, dlo, dhi;
	logic [3:0]      ncal;
	logic [CW-1:0]   n;
	logic            fin;
	logic signed [CM_W-1:0] xcm_q;
	logic [CM_W-1:0] ycm_q;

	assign q_stall = busy_q || done_q;
	assign row6 = 6'(q_row);
	assign ncal = (32'(q_row) < CAL_ROWS && 32'(q_row) < GRID_ROWS) ? cal_row_n(row6) : 4'd0;
	assign n = (32'(ncal) > MAX_ROW_POINTS) ? CW'(MAX_ROW_POINTS) : CW'(ncal);

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign vlo = cal_col_px(6'(row_q), 6'(lo_q));
	assign vhi = cal_col_px(6'(row_q), 6'(hi_q));
	assign vmid = cal_col_px(6'(row_q), 6'(mid));
	assign dlo = (vlo >= key) ? vlo - key : key - vlo;
	assign dhi = (vhi >= key) ? vhi - key : key - vhi;

	always_comb begin
		fin = 1'b1;
		col = mid;
		if (lo_q >= hi_q)
			col = lo_q;
		else if (lo_q + 1'b1 == hi_q) begin
			if (vlo == key)
				col = lo_q;
			else if (vhi == key)
				col = hi_q;
			else if (dlo <= dhi)
				col = lo_q;
			else
				col = hi_q;
		end else if (vmid != key)
			fin = 1'b0;
	end

	assign out_valid  = done_q;
	assign floor_x_cm = xcm_q;
	assign floor_y_cm = ycm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (q_valid && !q_stall) begin
			if (n == '0)
				done_q <= 1'b1;
			else
				busy_q <= 1'b1;
		end else if (busy_q) begin
			if (fin) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (done_q && !out_stall) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && !q_stall) begin
			key   <= q_pix.pixel_x;
			row_q <= q_row;
			lo_q  <= '0;
			hi_q  <= n - 1'b1;
			xcm_q <= '1;
			ycm_q <= (32'(q_row) < CAL_ROWS) ? CM_W'(20 + 5 * 32'(q_row)) : '0;
		end else if (busy_q) begin
			if (fin)
				xcm_q <= CM_W'(-10 - 5 * (32'(row_q) >> 1) + 5 * 32'(col));
			else if (vmid > key)
				hi_q <= mid;
			else
				lo_q <= mid;
		end
	end
endmodule

>>> rtl/core/pixel_to_grid_cm_lookup_unit.sv
`timescale 1ns / 1ps
// Maps a camera pixel to floor centimeters through a fixed calibration grid. The front stage
// picks the nearest row by a range-halving search over the row table, one probe a cycle (at
// most 5 probes for 12 rows), and hands the row through a two-beat queue to the back stage,
// which searches that row's column pixels the same way (at most 5 probes for 15 points) and
// holds the result until it is taken. Since front and back overlap, the front stage can
// accept a new pixel while the back stage still searches the row of the previous one.
module pixel_to_grid_cm_lookup_unit #(
	parameter int GRID_ROWS      = pgl_pkg::GRID_ROWS_DEF,
	parameter int MAX_ROW_POINTS = pgl_pkg::MAX_ROW_POINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pgl_pkg::PX_W-1:0]         pixel_x,
	input  logic [pgl_pkg::PX_W-1:0]         pixel_y,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [pgl_pkg::CM_W-1:0]  floor_x_cm,
	output logic [pgl_pkg::CM_W-1:0]         floor_y_cm
);
	import pgl_pkg::*;

	localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

	pix_t          in_pix, f_pix, b_pix;
	logic [RW-1:0] f_row, b_row;
	logic          f_valid, f_stall, b_valid, b_stall;

	assign in_pix.pixel_x = pixel_x;
	assign in_pix.pixel_y = pixel_y;

	pgl_front #(.GRID_ROWS(GRID_ROWS), .RW(RW)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_pix,
		.q_valid(f_valid), .q_stall(f_stall), .q_pix(f_pix), .q_row(f_row)
	);

	pgl_queue #(.RW(RW)) u_queue (
		.clk, .arst_n, .w_valid(f_valid), .w_stall(f_stall), .w_pix(f_pix), .w_row(f_row),
		.r_valid(b_valid), .r_stall(b_stall), .r_pix(b_pix), .r_row(b_row)
	);

	pgl_back #(.GRID_ROWS(GRID_ROWS), .MAX_ROW_POINTS(MAX_ROW_POINTS), .RW(RW)) u_back (
		.clk, .arst_n, .q_valid(b_valid), .q_stall(b_stall), .q_pix(b_pix), .q_row(b_row),
		.out_valid, .out_stall, .floor_x_cm, .floor_y_cm
	);

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid |-> 32'(f_row) < GRID_ROWS) else $error("row index out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(floor_y_cm))
		else $error("result changed while stalled");
	a_queue_flow: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && f_stall |=> b_valid) else $error("queue full but empty to back");
endmodule

>>> verif/pixel_to_grid_cm_lookup_unit_tb.sv
`timescale 1ns / 1ps
module pixel_to_grid_cm_lookup_unit_tb;
	import pgl_pkg::*;

	localparam int ROWS = 12;
	localparam int PTS = 15;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [PX_W-1:0] pixel_x;
	logic [PX_W-1:0] pixel_y;
	logic out_valid;
	logic out_stall;
	logic signed [CM_W-1:0] floor_x_cm;
	logic [CM_W-1:0] floor_y_cm;

	typedef struct packed {
		logic signed [CM_W-1:0] x_cm;
		logic [CM_W-1:0] y_cm;
	} floor_pos_t;

	floor_pos_t pending_pos[$];
	int send_idle_pct;
	int recv_stall_pct;
	int errors = 0;
	int cycle_count = 0;

	// Calibration grid kept locally for prediction.
	int row_px[ROWS] = '{472, 397, 339, 297, 262, 237, 213, 196, 180, 166, 155, 143};
	int row_n[ROWS] = '{5, 6, 7, 8, 9, 10, 11, 12, 13, 13, 15, 15};
	int col_px[ROWS][PTS] = '{
		'{60, 184, 311, 437, 561, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{99, 204, 311, 419, 524, 629, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{35, 128, 219, 312, 405, 497, 589, 0, 0, 0, 0, 0, 0, 0, 0},
		'{68, 153, 232, 313, 395, 476, 558, 637, 0, 0, 0, 0, 0, 0, 0},
		'{22, 96, 170, 242, 313, 386, 459, 533, 605, 0, 0, 0, 0, 0, 0},
		'{50, 117, 184, 250, 315, 380, 445, 512, 577, 538, 0, 0, 0, 0, 0},
		'{15, 75, 135, 196, 255, 315, 374, 434, 495, 554, 614, 0, 0, 0, 0},
		'{38, 94, 150, 206, 260, 315, 369, 424, 480, 535, 590, 640, 0, 0, 0},
		'{10, 59, 112, 163, 214, 265, 315, 365, 416, 468, 518, 568, 619, 0, 0},
		'{30, 77, 125, 173, 222, 269, 315, 362, 410, 458, 505, 551, 599, 0, 0},
		'{4, 49, 93, 138, 183, 227, 272, 316, 359, 403, 448, 493, 538, 580, 624},
		'{23, 66, 106, 149, 191, 233, 275, 316, 357, 398, 440, 481, 523, 563, 605}};

	pixel_to_grid_cm_lookup_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.floor_x_cm(floor_x_cm),
		.floor_y_cm(floor_y_cm)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Range-halving nearest search; the row table descends, the columns ascend.
	function automatic int nearest_index(int vals[PTS], int n, int key, bit descending);
		int lo;
		int hi;
		int mid;
		int dlo;
		int dhi;
		lo = 0;
		hi = n - 1;
		forever begin
			if (lo >= hi)
				return lo;
			if (lo + 1 == hi) begin
				if (vals[lo] == key)
					return lo;
				if (vals[hi] == key)
					return hi;
				dlo = (vals[lo] >= key) ? vals[lo] - key : key - vals[lo];
				dhi = (vals[hi] >= key) ? vals[hi] - key : key - vals[hi];
				return (dlo <= dhi) ? lo : hi;
			end
			mid = lo + (hi - lo) / 2;
			if (vals[mid] == key)
				return mid;
			if (descending) begin
				if (vals[mid] > key) lo = mid; else hi = mid;
			end else begin
				if (vals[mid] > key) hi = mid; else lo = mid;
			end
		end
	endfunction

	function automatic floor_pos_t predict_floor_pos(int px, int py);
		int rows[PTS];
		int row;
		int col;
		floor_pos_t p;
		rows = '{default: 0};
		for (int r = 0; r < ROWS; r++)
			rows[r] = row_px[r];
		row = nearest_index(rows, ROWS, py, 1'b1);
		col = nearest_index(col_px[row], row_n[row], px, 1'b0);
		p.x_cm = CM_W'(-10 - 5 * (row / 2) + 5 * col);
		p.y_cm = CM_W'(20 + 5 * row);
		return p;
	endfunction

	// Valid stays high after the accepting edge; the next call or the drain drops it.
	task automatic send_pixel(int px, int py);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= PX_W'(px);
		pixel_y <= PX_W'(py);
		pending_pos.insert(pending_pos.size(), predict_floor_pos(px, py));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		floor_pos_t exp_pos;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pos.size() == 0) begin
				$display("%0t: unexpected beat x=%0d y=%0d", $time, floor_x_cm, floor_y_cm);
				errors++;
			end else begin
				exp_pos = pending_pos.pop_front();
				if (floor_x_cm !== exp_pos.x_cm) begin
					$display("%0t: floor_x_cm expected %0d actual %0d", $time,
						exp_pos.x_cm, floor_x_cm);
					errors++;
				end
				if (floor_y_cm !== exp_pos.y_cm) begin
					$display("%0t: floor_y_cm expected %0d actual %0d", $time,
						exp_pos.y_cm, floor_y_cm);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pixel_to_grid_cm_lookup_unit test failed");
			$finish;
		end
	end

	task automatic test_field_extremes();
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(0, 1023);
		send_pixel(1023, 0);
		send_pixel(341, 682);
		send_pixel(682, 341);
	endtask

	task automatic test_exact_and_ties();
		// Exact row hits, a midpoint tie between rows, and exact column hits.
		send_pixel(60, 472);
		send_pixel(605, 143);
		send_pixel(315, 237);
		send_pixel(311, 368);
		send_pixel(122, 472);
		send_pixel(4, 155);
		send_pixel(624, 155);
	endtask

	task automatic test_out_of_order_entry();
		// The 45 cm row ends with 538 px after 577 px.
		send_pixel(538, 237);
		send_pixel(577, 237);
		send_pixel(560, 237);
		send_pixel(1000, 237);
		send_pixel(545, 240);
	endtask

	task automatic test_random_grid(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(ROWS - 1);
			case ($urandom_range(3))
				0: send_pixel($urandom_range(1023), $urandom_range(1023));
				1: send_pixel(col_px[r][$urandom_range(row_n[r] - 1)], row_px[r]);
				default: send_pixel($urandom_range(660), $urandom_range(130, 490));
			endcase
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pos.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_exact_and_ties();
		test_out_of_order_entry();
		test_random_grid(230);
		send_idle_pct = 59;
		test_random_grid(230);
		send_idle_pct = 0;
		recv_stall_pct = 59;
		test_random_grid(230);
		send_idle_pct = 26;
		recv_stall_pct = 26;
		test_random_grid(230);
		recv_stall_pct = 0;
		send_idle_pct = 0;
		wait_drained();
		if (errors == 0)
			$display("pixel_to_grid_cm_lookup_unit test passed");
		else
			$display("pixel_to_grid_cm_lookup_unit test failed");
		$finish;
	end
endmodule
